>>> rtl/kht_pkg.sv
// Shared types and constants for the keyed highest bid table.
`timescale 1ns / 1ps
`default_nettype none

package kht_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        FUNC_SET    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_RSVD   = 2'd3
    } func_t;

    typedef struct packed {
        logic [15:0] item;
        logic [15:0] user;
        logic [31:0] bid;
    } entry_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        logic   re;
        idx_t   raddr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/kht_entry_ram.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kht_entry_ram (
    input  wire logic             clk,
    input  wire kht_pkg::mem_req_t req,
    output kht_pkg::entry_t       rdata
);
    import kht_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/kht_ctrl.sv
// Request sequencer: scans the entry RAM, tracks match/free/best, writes back.
`timescale 1ns / 1ps
`default_nettype none

module kht_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       func,
    input  wire logic [15:0]      user_id,
    input  wire logic [15:0]      item_id,
    input  wire logic [31:0]      bid_amount,
    output logic                  done,
    output logic                  status,
    output logic                  found,
    output logic [15:0]           top_bidder,
    output kht_pkg::mem_req_t     req,
    input  wire kht_pkg::entry_t  rdata
);
    import kht_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]   func_reg;
    logic [15:0]  user_reg;
    logic [15:0]  item_reg;
    logic [31:0]  bid_reg;

    cnt_t         cnt_reg;
    logic         chk_vld_reg;
    idx_t         chk_idx_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic         match_hit_reg, free_hit_reg, any_reg;
    idx_t         match_idx_reg, free_idx_reg;
    logic [31:0]  best_bid_reg;
    logic [15:0]  best_user_reg;

    logic         done_reg, status_reg, found_reg;
    logic [15:0]  top_reg;

    logic         issue;
    logic         cur_valid;
    logic         item_eq;
    logic         key_eq;
    logic         better;
    logic         scan_end;

    assign busy     = (state_reg != ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign scan_end = (state_reg == ST_SCAN) && (cnt_reg == CNT_W'(TABLE_ENTRIES))
                      && !chk_vld_reg;

    assign cur_valid = valid_reg[chk_idx_reg];
    assign item_eq   = cur_valid && (rdata.item == item_reg);
    assign key_eq    = item_eq && (rdata.user == user_reg);
    assign better    = !any_reg || (rdata.bid > best_bid_reg)
                       || ((rdata.bid == best_bid_reg) && (rdata.user > best_user_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write back only at the end of the scan, so no read can see a stale entry.
    always_comb
    begin
        req.re          = issue;
        req.raddr       = cnt_reg[IDX_W-1:0];
        req.we          = 1'b0;
        req.waddr       = match_hit_reg ? match_idx_reg : free_idx_reg;
        req.wdata.item  = item_reg;
        req.wdata.user  = user_reg;
        req.wdata.bid   = bid_reg;
        if ((state_reg == ST_FINISH) && (func_reg == FUNC_SET)
            && (match_hit_reg || free_hit_reg))
        begin
            req.we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            chk_vld_reg <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= issue;
            done_reg    <= (state_reg == ST_FINISH);
            if (state_reg == ST_FINISH)
            begin
                case (func_reg)
                    FUNC_SET:
                    begin
                        if (match_hit_reg || free_hit_reg)
                        begin
                            valid_reg[req.waddr] <= 1'b1;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (match_hit_reg)
                        begin
                            valid_reg[match_idx_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            func_reg      <= func;
            user_reg      <= user_id;
            item_reg      <= item_id;
            bid_reg       <= bid_amount;
            cnt_reg       <= '0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            any_reg       <= 1'b0;
            best_bid_reg  <= '0;
            best_user_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg     <= cnt_reg + CNT_W'(1);
                chk_idx_reg <= cnt_reg[IDX_W-1:0];
            end
            if (chk_vld_reg)
            begin
                if (key_eq && !match_hit_reg)
                begin
                    match_hit_reg <= 1'b1;
                    match_idx_reg <= chk_idx_reg;
                end
                // Take the lowest-numbered free slot.
                if (!cur_valid && !free_hit_reg)
                begin
                    free_hit_reg <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
                if (item_eq && better)
                begin
                    any_reg       <= 1'b1;
                    best_bid_reg  <= rdata.bid;
                    best_user_reg <= rdata.user;
                end
            end
        end
        if (state_reg == ST_FINISH)
        begin
            status_reg <= (func_reg == FUNC_SET) && !match_hit_reg && !free_hit_reg;
            found_reg  <= (func_reg == FUNC_QUERY) && any_reg;
            top_reg    <= ((func_reg == FUNC_QUERY) && any_reg) ? best_user_reg : 16'd0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign top_bidder = top_reg;

endmodule

`default_nettype wire

>>> rtl/keyed_highest_bid_table.sv
// Top level of the keyed highest bid table: sequencer, entry RAM, checks.
//
// Channel   Handshake                 Payload
// request   start, accepted when !busy func, user_id, item_id, bid_amount
// result    done, one-cycle strobe     status, found, top_bidder
//
// Each request scans every entry once through the single RAM read port; the
// result beat appears in the cycle busy falls, when the next start is taken.
// Reset clears all valid bits at once; no clearing pass is needed.
// The result beat cannot be stalled; it is present for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module keyed_highest_bid_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] user_id,
    input  wire logic [15:0] item_id,
    input  wire logic [31:0] bid_amount,
    output logic             done,
    output logic             status,
    output logic             found,
    output logic [15:0]      top_bidder
);
    import kht_pkg::*;

    mem_req_t req;
    entry_t   rdata;

    kht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .user_id    (user_id),
        .item_id    (item_id),
        .bid_amount (bid_amount),
        .done       (done),
        .status     (status),
        .found      (found),
        .top_bidder (top_bidder),
        .req        (req),
        .rdata      (rdata)
    );

    kht_entry_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a request in flight");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("more than one result beat for a request");

    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(found && status) && (found || (top_bidder == 16'd0))))
        else $error("inconsistent result fields");

endmodule

`default_nettype wire
